[design/brlo_pkg.sv]
// Shared types, constants and register indexes for the Bresenham log-odds ray update block.
`default_nettype none
package brlo_pkg;

  // Default side length of the square cell store.
  localparam int MAX_SIDE_DEFAULT = 256;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREE_DELTA     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OCCUPIED_DELTA = 2'd3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [8:0]  GRID_SIDE_RESET = 9'd256;
  localparam logic [15:0] DELTA_RESET     = 16'd0;

  // Operation codes.
  localparam logic OP_TRACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               ray_hit;
  } request_t;

  typedef struct packed {
    logic signed [15:0] cell_value;
    logic               cell_in_grid;
    logic [15:0]        cells_visited;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic walk;
    logic finish_trace;
    logic read_issue;
    logic finish_read;
  } command_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic at_end;
  } status_t;

endpackage
`default_nettype wire

[design/bresenham_logodds_ray_update.sv]
// Top level of the Bresenham ray cast log-odds occupancy grid update block.
//
//   Channel   Signals                               Handshake
//   -------   -----------------------------------   ------------------------------------
//   request   start, busy, request                  beat when start is high and busy low
//   result    done, result                          beat on every cycle done is high
//   config    cfg_valid, cfg_ready, cfg_index,      beat when cfg_valid and cfg_ready
//             cfg_data
//
// A trace passes the accept cycle, the walk state, which visits one cell a cycle through
// the read-modify-write pipeline on the cell store, and the drain state, which finishes
// the last store write; done is high in the cycle after the drain state. A read passes
// the accept cycle and the read-issue and read-out states; done is high in the cycle
// after read-out. After reset all MAX_SIDE * MAX_SIDE cells (65536 at the default size)
// are cleared, one cell a cycle, with busy high, while configuration beats are taken.
// The receiver cannot stall: done is high for exactly one cycle per result, and a new
// request may be accepted in the same cycle that done is high.
`default_nettype none
module bresenham_logodds_ray_update #(
  parameter int MAX_SIDE = brlo_pkg::MAX_SIDE_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire brlo_pkg::request_t               request,
  output logic                                  done,
  output brlo_pkg::result_t                     result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [brlo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [brlo_pkg::CFG_DATA_W-1:0]  cfg_data
);

  brlo_pkg::command_t command;
  brlo_pkg::status_t  status;

  // Configuration registers are plain flops and can take a beat every cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences the clearing pass, the walk and the single-cell read.
  brlo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .status    (status),
    .command   (command),
    .busy      (busy),
    .done      (done)
  );

  // The datapath holds the registers, the walker and the cell store.
  brlo_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .command   (command),
    .status    (status),
    .result    (result)
  );

endmodule
`default_nettype wire

[design/brlo_ctrl.sv]
// Controller state machine for the Bresenham log-odds ray update block.
`default_nettype none
module brlo_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               operation,
  input  wire brlo_pkg::status_t  status,
  output brlo_pkg::command_t      command,
  output logic                    busy,
  output logic                    done
);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_WALK     = 6'b000100,
    S_DRAIN    = 6'b001000,
    S_READ_MEM = 6'b010000,
    S_READ_OUT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    command    = '0;
    unique case (state)
      S_CLEAR: begin
        command.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          command.load = 1'b1;
          state_next = (operation == brlo_pkg::OP_READ) ? S_READ_MEM : S_WALK;
        end
      end
      S_WALK: begin
        command.walk = 1'b1;
        if (status.at_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        command.finish_trace = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_READ_MEM: begin
        command.read_issue = 1'b1;
        state_next = S_READ_OUT;
      end
      S_READ_OUT: begin
        command.finish_read = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  // A result strobe only follows the last cycle of a trace or a read.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_DRAIN || $past(state) == S_READ_OUT))
    else $error("result strobe without a finished item");

  // An accepted item always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_WALK || state == S_READ_MEM))
    else $error("accepted item did not start work");

  // The walk continues until the end cell is reached.
  a_walk_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !status.at_end) |=> (state == S_WALK))
    else $error("walk left before the end cell");

endmodule
`default_nettype wire

[design/brlo_datapath.sv]
// Datapath: configuration registers, Bresenham walker, cell store and saturating update.
`default_nettype none
module brlo_datapath #(
  parameter int MAX_SIDE = brlo_pkg::MAX_SIDE_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [brlo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [brlo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire brlo_pkg::request_t                   request,
  input  wire brlo_pkg::command_t                   command,
  output brlo_pkg::status_t                         status,
  output brlo_pkg::result_t                         result
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_SIDE);
  localparam logic [AW-1:0] SIDE_A    = AW'(MAX_SIDE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [15:0]   SIDE_16   = 16'(MAX_SIDE);

  // Configuration registers.
  logic [8:0]  grid_width;
  logic [8:0]  grid_height;
  logic [15:0] free_incr;
  logic [15:0] hit_incr;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= brlo_pkg::GRID_SIDE_RESET;
      grid_height <= brlo_pkg::GRID_SIDE_RESET;
      free_incr   <= brlo_pkg::DELTA_RESET;
      hit_incr    <= brlo_pkg::DELTA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        brlo_pkg::CFG_GRID_WIDTH:     grid_width  <= cfg_data[8:0];
        brlo_pkg::CFG_GRID_HEIGHT:    grid_height <= cfg_data[8:0];
        brlo_pkg::CFG_FREE_DELTA:     free_incr   <= cfg_data;
        brlo_pkg::CFG_OCCUPIED_DELTA: hit_incr    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid sides in use, clamped to the store.
  logic [15:0] side_w;
  logic [15:0] side_h;
  assign side_w = (16'(grid_width) > SIDE_16) ? SIDE_16 : 16'(grid_width);
  assign side_h = (16'(grid_height) > SIDE_16) ? SIDE_16 : 16'(grid_height);

  // Walk state.
  logic signed [15:0] walk_x;
  logic signed [15:0] walk_y;
  logic signed [17:0] walk_error;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic               x_neg;
  logic               y_neg;
  logic               hit;
  logic [15:0]        count;

  // Setup terms taken straight from the request.
  logic signed [16:0] diff_x;
  logic signed [16:0] diff_y;
  logic        [16:0] abs_x;
  logic        [16:0] abs_y;
  logic signed [17:0] dx_new;
  logic signed [17:0] dy_new;

  assign diff_x = {request.end_x[15], request.end_x} - {request.start_x[15], request.start_x};
  assign diff_y = {request.end_y[15], request.end_y} - {request.start_y[15], request.start_y};
  assign abs_x  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
  assign abs_y  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
  assign dx_new = signed'({1'b0, abs_x});
  assign dy_new = -signed'({1'b0, abs_y});

  // One Bresenham step.
  logic signed [18:0] twice;
  logic               step_x;
  logic               step_y;
  logic               at_end;
  logic               cur_in;
  logic [AW-1:0]      cur_addr;
  logic [15:0]        cur_delta;

  assign twice  = {walk_error, 1'b0};
  assign step_x = (twice >= 19'(dy));
  assign step_y = (twice <= 19'(dx));
  assign at_end = (walk_x == end_x) && (walk_y == end_y);
  assign cur_in = !walk_x[15] && !walk_y[15] &&
                  (16'(walk_x) < side_w) && (16'(walk_y) < side_h);
  assign cur_addr = AW'(walk_y[CW-1:0]) * SIDE_A + AW'(walk_x[CW-1:0]);
  assign cur_delta = (at_end && hit) ? hit_incr : free_incr;

  always_ff @(posedge clk) begin
    if (command.load) begin
      walk_x     <= request.start_x;
      walk_y     <= request.start_y;
      walk_error <= dx_new + dy_new;
      end_x      <= request.end_x;
      end_y      <= request.end_y;
      dx         <= dx_new;
      dy         <= dy_new;
      x_neg      <= !(request.start_x < request.end_x);
      y_neg      <= !(request.start_y < request.end_y);
      hit        <= request.ray_hit;
      count      <= '0;
    end else if (command.walk) begin
      count <= (count == 16'hFFFF) ? count : count + 16'd1;
      if (!at_end) begin
        walk_error <= walk_error + (step_x ? dy : 18'sd0) + (step_y ? dx : 18'sd0);
        if (step_x) begin
          walk_x <= walk_x + (x_neg ? 16'hFFFF : 16'h0001);
        end
        if (step_y) begin
          walk_y <= walk_y + (y_neg ? 16'hFFFF : 16'h0001);
        end
      end
    end
  end

  // Pending write of the cell read in the previous cycle.
  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  logic [15:0]   pend_delta;
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      clear_addr <= '0;
    end else begin
      pend_valid <= command.walk && cur_in;
      if (command.clear_step) begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr  <= cur_addr;
    pend_delta <= cur_delta;
  end

  // Cell store with one write and one registered read port.
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [16:0]   sum;
  logic [15:0]   sat_sum;

  assign rd_en   = (command.walk && cur_in) || command.read_issue;
  assign sum     = {rdata[15], rdata} + {pend_delta[15], pend_delta};
  assign sat_sum = (sum[16] != sum[15]) ? (sum[16] ? 16'h8000 : 16'h7FFF) : sum[15:0];
  assign wr_en   = command.clear_step || pend_valid;
  assign wr_addr = command.clear_step ? clear_addr : pend_addr;
  assign wr_data = command.clear_step ? 16'd0 : sat_sum;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[cur_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (command.finish_trace) begin
      result.cell_value    <= '0;
      result.cell_in_grid  <= 1'b0;
      result.cells_visited <= count;
    end else if (command.finish_read) begin
      result.cell_value    <= cur_in ? signed'(rdata) : 16'sd0;
      result.cell_in_grid  <= cur_in;
      result.cells_visited <= '0;
    end
  end

  assign status.clear_last = (clear_addr == LAST_ADDR);
  assign status.at_end     = at_end;

  // The pipelined write never lands on the cell being read in the same cycle.
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && rd_en) |-> (pend_addr != cur_addr))
    else $error("read and write of the same cell in one cycle");

endmodule
`default_nettype wire
